### sv/ytb_pkg.sv
// shared constants, coefficient values and types for the yuyv to bgr888 converter
package ytb_pkg;

  // fraction bits of the fixed-point chroma coefficients
  localparam int COEF_FRAC_BITS = 16;

  localparam longint ONE_Q = longint'(1) << COEF_FRAC_BITS;
  // full-range bt.601 coefficients, rounded to nearest
  localparam longint KR_Q  = (ONE_Q * 1402 + 500) / 1000;
  localparam longint KGB_Q = (ONE_Q * 34414 + 50000) / 100000;
  localparam longint KGR_Q = (ONE_Q * 71414 + 50000) / 100000;
  localparam longint KB_Q  = (ONE_Q * 1772 + 500) / 1000;

  // coefficients are below 4.0, plus a sign bit
  localparam int KCOEF_W = COEF_FRAC_BITS + 3;
  // coefficient times an 8-bit signed chroma offset
  localparam int PROD_W  = KCOEF_W + 8;
  // luma plus chroma terms stays well below 1024 in magnitude
  localparam int ACC_W   = PROD_W + 1;

  localparam logic signed [KCOEF_W-1:0] KR  = KCOEF_W'(KR_Q);
  localparam logic signed [KCOEF_W-1:0] KGB = KCOEF_W'(KGB_Q);
  localparam logic signed [KCOEF_W-1:0] KGR = KCOEF_W'(KGR_Q);
  localparam logic signed [KCOEF_W-1:0] KB  = KCOEF_W'(KB_Q);

  typedef logic signed [PROD_W-1:0] prod_t;

  // chroma products shared by both pixel lanes
  typedef struct packed {
    prod_t b_du;
    prod_t g_du;
    prod_t g_dv;
    prod_t r_dv;
  } chroma_terms_t;

  // one output pixel, red in the high byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgr_t;

endpackage

### sv/ytb_chroma.sv
// chroma product unit: offsets cb and cr and multiplies them by the coefficients
module ytb_chroma (
  input  logic [7:0]             chroma_blue,
  input  logic [7:0]             chroma_red,
  output ytb_pkg::chroma_terms_t terms
);
  import ytb_pkg::*;

  logic signed [7:0] du;
  logic signed [7:0] dv;

  // subtracting 128 from an unsigned byte flips its top bit
  assign du = {~chroma_blue[7], chroma_blue[6:0]};
  assign dv = {~chroma_red[7], chroma_red[6:0]};

  assign terms.b_du = KB * du;
  assign terms.g_du = KGB * du;
  assign terms.g_dv = KGR * dv;
  assign terms.r_dv = KR * dv;

endmodule

### sv/ytb_lane.sv
// pixel lane: adds luma to the chroma terms and truncates each channel to 8 bits
module ytb_lane (
  input  logic [7:0]             luma,
  input  ytb_pkg::chroma_terms_t terms,
  output ytb_pkg::bgr_t          pixel
);
  import ytb_pkg::*;

  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_b;
  logic signed [ACC_W-1:0] acc_g;
  logic signed [ACC_W-1:0] acc_r;

  // truncate toward zero: negative values with a nonzero fraction move up by one
  function automatic logic [7:0] trunc_wrap8(input logic signed [ACC_W-1:0] acc);
    logic bump;
    bump = acc[ACC_W-1] & (|acc[COEF_FRAC_BITS-1:0]);
    return acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS] + {7'd0, bump};
  endfunction

  assign base  = $signed(ACC_W'(luma) << COEF_FRAC_BITS);
  assign acc_b = base + ACC_W'(terms.b_du);
  assign acc_g = base - ACC_W'(terms.g_du) - ACC_W'(terms.g_dv);
  assign acc_r = base + ACC_W'(terms.r_dv);

  assign pixel.blue  = trunc_wrap8(acc_b);
  assign pixel.green = trunc_wrap8(acc_g);
  assign pixel.red   = trunc_wrap8(acc_r);

endmodule

### sv/yuyv_to_bgr888_converter_unit.sv
// top level of the yuyv to bgr888 converter: pipeline control, lanes and output register
//
// Converts one packed yuyv macropixel per transaction into two bgr888 pixels that share
// the chroma pair, using full-range bt.601 coefficients in signed fixed point with
// COEF_FRAC_BITS fraction bits. Each channel is truncated toward zero and wrapped to its
// low 8 bits (no clamping). The block takes one macropixel every clock while the output is
// not stalled. The first stage registers the four chroma products; the second stage runs
// the two pixel lanes and holds the result in the output register. Throughput is one
// transaction per clock when the output does not stall; a stalled output only holds the
// stages behind it once they are full. tlast passes through unchanged.
module yuyv_to_bgr888_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // luma_first, chroma_blue, luma_second, chroma_red
  input  logic        in_tlast,   // frame_end_in
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // blue_first, green_first, red_first,
                                  // blue_second, green_second, red_second
  output logic        out_tlast   // frame_end_out
);
  import ytb_pkg::*;

  // stage 1: chroma products and luma samples
  logic          s1_valid_r, s1_valid_nxt;
  chroma_terms_t s1_terms_r;
  logic [7:0]    s1_luma0_r;
  logic [7:0]    s1_luma1_r;
  logic          s1_last_r;

  // stage 2: output register
  logic          s2_valid_r, s2_valid_nxt;
  logic [47:0]   s2_data_r;
  logic          s2_last_r;

  logic          s1_load;
  logic          s2_load;
  logic          s2_free;
  chroma_terms_t terms;
  bgr_t          pixel0;
  bgr_t          pixel1;

  // a stage may load when it is empty or its content moves on this cycle
  assign s2_free   = !s2_valid_r || out_tready;
  assign s2_load   = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;
  assign s1_load   = in_tvalid && in_tready;

  ytb_chroma u_chroma (
    .chroma_blue (in_tdata[15:8]),
    .chroma_red  (in_tdata[31:24]),
    .terms       (terms)
  );

  // one lane per pixel of the macropixel
  ytb_lane u_lane0 (
    .luma  (s1_luma0_r),
    .terms (s1_terms_r),
    .pixel (pixel0)
  );

  ytb_lane u_lane1 (
    .luma  (s1_luma1_r),
    .terms (s1_terms_r),
    .pixel (pixel1)
  );

  always_comb begin
    s1_valid_nxt = s1_load || (s1_valid_r && !s2_free);
    s2_valid_nxt = s1_valid_r || (s2_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_terms_r <= terms;
      s1_luma0_r <= in_tdata[7:0];
      s1_luma1_r <= in_tdata[23:16];
      s1_last_r  <= in_tlast;
    end
  end

  // merge the two lanes into the packed output word
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_data_r <= {pixel1.red, pixel1.green, pixel1.blue,
                    pixel0.red, pixel0.green, pixel0.blue};
      s2_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = s2_data_r;
  assign out_tlast  = s2_last_r;

`ifndef SYNTH
  // an accepted transaction always lands in stage 1
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted transaction lost before stage 1");

  // a stage 1 item blocked by a full output is kept
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_free) |=> s1_valid_r)
    else $error("stage 1 item dropped while stalled");

  // the frame end marker follows its item into the output register
  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> (out_tvalid && out_tlast == $past(s1_last_r)))
    else $error("frame end marker not carried to output");
`endif

endmodule

### verif/yuyv_to_bgr888_converter_unit_tb.sv
`timescale 1ns / 100ps
// self-checking stream testbench for the yuyv to bgr888 converter top level
module yuyv_to_bgr888_converter_unit_tb;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int TAIL_CYCLES    = 8;
  localparam int LIMIT_CYCLES   = 200_000;

  // channel offsets inside one pixel of the result word
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // bt.601 full-range coefficients at the block's fraction width, rounded to nearest
  localparam int     FRAC_BITS = ytb_pkg::COEF_FRAC_BITS;
  localparam longint UNIT_Q    = longint'(1) << FRAC_BITS;
  localparam longint CR_TO_R   = (UNIT_Q * 1402 + 500) / 1000;
  localparam longint CB_TO_G   = (UNIT_Q * 34414 + 50000) / 100000;
  localparam longint CR_TO_G   = (UNIT_Q * 71414 + 50000) / 100000;
  localparam longint CB_TO_B   = (UNIT_Q * 1772 + 500) / 1000;

  // one macropixel as it travels on the input channel
  typedef struct packed {
    logic        frame_end;
    logic [31:0] word;       // y0, u, y1, v from the lowest byte up
  } macropixel_t;

  // one pixel pair laid out exactly as {out_tlast, out_tdata}
  typedef struct packed {
    logic            frame_end;
    logic [5:0][7:0] chan;   // b0, g0, r0, b1, g1, r1 from the lowest byte up
  } bgr_pair_t;

  string chan_name [6] = '{"blue_first", "green_first", "red_first",
                           "blue_second", "green_second", "red_second"};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // luma_first, chroma_blue, luma_second, chroma_red
  logic        in_tlast = 1'b0; // frame_end_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // blue_first, green_first, red_first,
                                // blue_second, green_second, red_second
  logic        out_tlast;       // frame_end_out

  macropixel_t pending_pixels [$];   // macropixels waiting to be offered
  bgr_pair_t   expected_pairs [$];   // converted pairs still owed by the block
  macropixel_t next_item;

  int send_idle_pct = 11;
  int recv_idle_pct = 83;
  int items_queued  = 0;
  int items_in      = 0;
  int frames_in     = 0;
  int results_out   = 0;
  int stall_cycles  = 0;
  int fail_count    = 0;
  int frame_left    = 0;
  bit in_taken      = 1'b0;

  // long receiver hold-off, armed once during the no-idle phase
  bit holdoff_arm  = 1'b0;
  bit holdoff_done = 1'b0;
  int holdoff_at   = 0;
  int holdoff_left = 0;

  yuyv_to_bgr888_converter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // truncate a q-format sum toward zero, then keep the low byte (no clamping)
  function automatic logic [7:0] wrap_channel(longint acc);
    longint whole;
    whole = acc / UNIT_Q;   // signed division rounds toward zero
    return whole[7:0];
  endfunction

  // expected pixel pair for one macropixel; both pixels share the chroma pair
  function automatic bgr_pair_t convert_macropixel(macropixel_t mp);
    bgr_pair_t  px;
    longint     du;
    longint     dv;
    longint     base;
    logic [7:0] luma [2];
    int         lane;
    luma[0] = mp.word[7:0];
    luma[1] = mp.word[23:16];
    du = longint'(mp.word[15:8]) - 128;
    dv = longint'(mp.word[31:24]) - 128;
    for (lane = 0; lane < 2; lane++) begin
      base = longint'(luma[lane]) * UNIT_Q;
      px.chan[3*lane + CH_BLUE]  = wrap_channel(base + CB_TO_B * du);
      px.chan[3*lane + CH_GREEN] = wrap_channel(base - CB_TO_G * du - CR_TO_G * dv);
      px.chan[3*lane + CH_RED]   = wrap_channel(base + CR_TO_R * dv);
    end
    px.frame_end = mp.frame_end;
    return px;
  endfunction

  // random sample, leaning toward the corners of the range now and then
  function automatic logic [7:0] pick_sample();
    logic [7:0] corner [5] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd255};
    if ($urandom_range(7) == 0) return corner[$urandom_range(4)];
    return 8'($urandom);
  endfunction

  task automatic add_item(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v,
                          logic last);
    pending_pixels.push_back({last, v, y1, u, y0});
    items_queued++;
  endtask

  // random macropixels grouped into frames of random length
  task automatic queue_random(int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (frame_left == 0) frame_left = $urandom_range(24, 1);
      frame_left--;
      add_item(pick_sample(), pick_sample(), pick_sample(), pick_sample(), frame_left == 0);
    end
  endtask

  // waits until every queued macropixel has been accepted and has come back converted
  task automatic drain();
    do @(negedge clk);
    while (items_in != items_queued || expected_pairs.size() != 0);
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_result(bgr_pair_t got);
    bgr_pair_t want;
    int        k;
    results_out++;
    if (expected_pairs.size() == 0) begin
      note_failure($sformatf("result %0d arrived with nothing expected: %013h",
                             results_out, got));
    end else begin
      want = expected_pairs.pop_front();
      for (k = 0; k < 6; k++) begin
        if (got.chan[k] !== want.chan[k])
          note_failure($sformatf("result %0d %s: expected %02h, got %02h",
                                 results_out, chan_name[k], want.chan[k], got.chan[k]));
      end
      if (got.frame_end !== want.frame_end)
        note_failure($sformatf("result %0d frame_end_out: expected %0b, got %0b",
                               results_out, want.frame_end, got.frame_end));
    end
  endtask

  // driver: offers the next macropixel once the previous transaction has completed
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_pixels.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
        next_item = pending_pixels.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_item.word;
        in_tlast  <= next_item.frame_end;
      end else begin
        // idle cycle: junk on the data lines must be ignored
        in_tvalid <= 1'b0;
        in_tdata  <= $urandom;
        in_tlast  <= 1'($urandom);
      end
    end
  end

  // receiver: random back-pressure, plus the long hold-off when it runs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (holdoff_left == 0) && (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  // hold-off counter, in cycles
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_arm && !holdoff_done && items_in >= holdoff_at) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end
  end

  // monitor: predicts on every input transaction, checks every output transaction
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_pairs.push_back(convert_macropixel({in_tlast, in_tdata}));
        items_in++;
        if (in_tlast) frames_in++;
        in_taken = 1'b1;
      end
      if (in_tvalid && !in_tready) stall_cycles++;
      if (out_tvalid && out_tready) check_result({out_tlast, out_tdata});
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: range extremes, neutral chroma, wrap in every channel,
    // truncation toward zero on small negative terms, alternating bit patterns
    add_item(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    add_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    add_item(8'd0,   8'd128, 8'd255, 8'd128, 1'b0);
    add_item(8'd255, 8'd128, 8'd0,   8'd128, 1'b1);
    add_item(8'd255, 8'd128, 8'd200, 8'd255, 1'b0);  // red above 255
    add_item(8'd0,   8'd128, 8'd10,  8'd0,   1'b0);  // red below zero
    add_item(8'd0,   8'd128, 8'd0,   8'd127, 1'b0);  // red of -1.4 truncates to -1
    add_item(8'd0,   8'd127, 8'd0,   8'd128, 1'b1);  // blue of -1.7 truncates to -1
    add_item(8'd255, 8'd255, 8'd128, 8'd128, 1'b0);  // blue above 255
    add_item(8'd0,   8'd0,   8'd20,  8'd128, 1'b0);  // blue below zero
    add_item(8'd255, 8'd0,   8'd250, 8'd0,   1'b0);  // green above 255
    add_item(8'd0,   8'd255, 8'd5,   8'd255, 1'b1);  // green below zero
    add_item(8'haa,  8'h55,  8'h55,  8'haa,  1'b0);
    add_item(8'h55,  8'haa,  8'haa,  8'h55,  1'b1);
    add_item(8'd1,   8'd129, 8'd254, 8'd127, 1'b0);
    add_item(8'd128, 8'd1,   8'd127, 8'd254, 1'b1);

    // sender mostly busy, receiver mostly stalling
    queue_random(400);
    drain();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 83;
    recv_idle_pct = 11;
    queue_random(420);
    drain();

    // no idling; a long hold-off mid-stream fills the pipeline and stalls the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_at    = items_in + 40;
    holdoff_arm   = 1'b1;
    queue_random(420);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_pairs.size() != 0)
      note_failure($sformatf("%0d converted pairs never arrived", expected_pairs.size()));

    $display("converted %0d macropixels in %0d frames under three idle patterns, %0d checked",
             items_in, frames_in, results_out);
    $display("input held off for %0d cycles, including one %0d-cycle output stall; %0d failures",
             stall_cycles, HOLDOFF_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d of %0d macropixels accepted, %0d results outstanding",
             items_in, items_queued, expected_pairs.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
